// ----- rtl/tcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpd_pkg: shared types and constants for the two-class priority deque
// Status codes, operation kinds, register indexes and reset values used by
// the channel interfaces and the deque logic.
// ----------------------------------------------------------------------------
package tcpd_pkg;

  // Field widths fixed by the item format
  localparam int KEY_W    = 16;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 3;
  localparam int WAIT_W   = 5;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_SERVED    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Operation kind of an input item
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_LIMIT   = 1'b1;

  // Register reset values
  localparam logic [AGE_W-1:0] YOUNG_LIMIT_RESET = 8'd18;
  localparam logic [AGE_W-1:0] OLD_LIMIT_RESET   = 8'd60;

endpackage

// ----- rtl/tcpd_in_if.sv -----
// ----------------------------------------------------------------------------
// tcpd_in_if: input item channel
// Valid/ready channel carrying one enqueue or dequeue request.
// ----------------------------------------------------------------------------
interface tcpd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tcpd_pkg::KEY_W-1:0]   entry_key;
  logic [tcpd_pkg::AGE_W-1:0]   entry_age;

  modport source (output valid, output kind, output entry_key, output entry_age,
                  input ready);
  modport sink   (input valid, input kind, input entry_key, input entry_age,
                  output ready);
endinterface

// ----- rtl/tcpd_out_if.sv -----
// ----------------------------------------------------------------------------
// tcpd_out_if: result item channel
// Valid/ready channel carrying one status result with occupancy.
// ----------------------------------------------------------------------------
interface tcpd_out_if;
  logic                          valid;
  logic                          ready;
  tcpd_pkg::status_t             status;
  logic [tcpd_pkg::KEY_W-1:0]    served_key;
  logic [tcpd_pkg::AGE_W-1:0]    served_age;
  logic [tcpd_pkg::WAIT_W-1:0]   waiting;
  logic                          is_empty;

  modport source (output valid, output status, output served_key,
                  output served_age, output waiting, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input served_key,
                  input served_age, input waiting, input is_empty,
                  output ready);
endinterface

// ----- rtl/tcpd_store.sv -----
// ----------------------------------------------------------------------------
// tcpd_store: ring entry memory
// One write port and one registered read port holding key and age per slot.
// ----------------------------------------------------------------------------
module tcpd_store #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [tcpd_pkg::KEY_W-1:0]    wr_key,
  input  logic [tcpd_pkg::AGE_W-1:0]    wr_age,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [tcpd_pkg::KEY_W-1:0]    rd_key,
  output logic [tcpd_pkg::AGE_W-1:0]    rd_age
);
  import tcpd_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [AGE_W-1:0] age_mem [DEPTH];

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      age_mem[wr_addr] <= wr_age;
    end
  end

  // Read one slot, data valid next cycle
  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_age <= age_mem[rd_addr];
  end

endmodule

// ----- rtl/two_class_priority_deque.sv -----
// ----------------------------------------------------------------------------
// two_class_priority_deque: bounded deque with front insert for two age classes
// Ring of DEPTH (key, age) slots with duplicate-key rejection and status output.
// ----------------------------------------------------------------------------
// Takes one item at a time. An enqueue scans the queued keys through the entry
// memory's single read port, one key per cycle, with one shared key comparator,
// then writes the entry in S_WRITE, or reports a full queue, and stops early
// when a duplicate is found. A dequeue reads the head slot in S_DEQ and serves
// it in S_SERVE, while a dequeue of an empty queue skips both states. The
// next item is taken once the result is in the output register; the output
// register holds a result until it is taken. Entries whose age is at or below
// young_limit or at or above old_limit go to the front, others to the back.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module two_class_priority_deque #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tcpd_in_if.sink                           in_ch,
  tcpd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcpd_pkg::CFG_W-1:0]        cfg_data
);
  import tcpd_pkg::*;

  localparam int IDXW = $clog2(DEPTH);
  localparam int OCCW = $clog2(DEPTH + 1);
  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(DEPTH - 1);
  localparam logic [OCCW-1:0] FULL_OCC  = OCCW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEQ   = 6'b000100,
    S_SERVE = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDXW-1:0]   head_r, head_nxt;
  logic [OCCW-1:0]   occ_r, occ_nxt;
  logic [OCCW-1:0]   cnt_r, cnt_nxt;
  logic [IDXW-1:0]   ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AGE_W-1:0]  young_r, old_r;

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [AGE_W-1:0]  age_r, age_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [AGE_W-1:0]  res_age_r, res_age_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [AGE_W-1:0]  out_age_r;
  logic [WAIT_W-1:0] out_wait_r;
  logic              out_empty_r;

  logic              mem_we;
  logic [IDXW-1:0]   mem_waddr, mem_raddr;
  logic [KEY_W-1:0]  rd_key;
  logic [AGE_W-1:0]  rd_age;

  logic              in_take, out_load, issue, match, front;
  logic [IDXW-1:0]   head_dec, head_inc, ptr_inc;
  logic [31:0]       occ_ext;

  tcpd_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_key  (key_r),
    .wr_age  (age_r),
    .rd_addr (mem_raddr),
    .rd_key  (rd_key),
    .rd_age  (rd_age)
  );

  // Ring pointer steps
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;

  // Shared key comparator and age class decision
  assign issue = (cnt_r != occ_r);
  assign match = pend_r && (rd_key == key_r);
  assign front = (age_r <= young_r) || (age_r >= old_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    key_nxt        = key_r;
    age_nxt        = age_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_age_nxt    = res_age_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_raddr      = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          key_nxt     = in_ch.entry_key;
          age_nxt     = in_ch.entry_age;
          res_key_nxt = '0;
          res_age_nxt = '0;
          cnt_nxt     = '0;
          ptr_nxt     = head_r;
          if (in_ch.kind == KIND_DEQ) begin
            if (occ_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_DEQ;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_DEQ: begin
        mem_raddr = head_r;
        state_nxt = S_SERVE;
      end
      S_SERVE: begin
        res_status_nxt = ST_SERVED;
        res_key_nxt    = rd_key;
        res_age_nxt    = rd_age;
        head_nxt       = head_inc;
        occ_nxt        = occ_r - 1'b1;
        state_nxt      = S_DONE;
      end
      S_SCAN: begin
        // Issue the next queued key, compare the one read last cycle
        mem_raddr = ptr_r;
        if (issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          ptr_nxt  = ptr_inc;
          pend_nxt = 1'b1;
        end
        if (match) begin
          res_status_nxt = ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else if (!issue) begin
          if (occ_r == FULL_OCC) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        // Front insert moves head back; back insert uses the slot after the tail
        mem_we = 1'b1;
        if (front) begin
          mem_waddr = head_dec;
          head_nxt  = head_dec;
        end else begin
          mem_waddr = ptr_r;
        end
        occ_nxt        = occ_r + 1'b1;
        res_status_nxt = ST_ADDED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      cnt_r   <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    age_r        <= age_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_age_r    <= res_age_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      young_r <= YOUNG_LIMIT_RESET;
      old_r   <= OLD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_YOUNG_LIMIT: young_r <= cfg_data;
        CFG_OLD_LIMIT:   old_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  assign occ_ext = 32'(occ_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_age_r    <= res_age_r;
      out_wait_r   <= occ_ext[WAIT_W-1:0];
      out_empty_r  <= (occ_r == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.served_key = out_key_r;
  assign out_ch.served_age = out_age_r;
  assign out_ch.waiting    = out_wait_r;
  assign out_ch.is_empty   = out_empty_r;

endmodule
